// File: rtl/core/crct_pkg.sv
package crct_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [24:0] ALL_BLOCKS = 25'h1000000;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_RESET_FULL   = 4'd0,
    ST_COVERED_FULL = 4'd1,
    ST_EXTENDED     = 4'd2,
    ST_COVERED      = 4'd3,
    ST_NEW          = 4'd4,
    ST_DISCARD      = 4'd5,
    ST_ADVANCED     = 4'd6,
    ST_FREED        = 4'd7,
    ST_READ         = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] image_id;
    logic [23:0] block;
    logic        whole_image;
    logic [7:0]  slot;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot_used;
    logic        entry_valid;
    logic [15:0] entry_image;
    logic [23:0] entry_block;
    logic [24:0] entry_count;
    logic        entry_full;
    logic [8:0]  fill_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] image;
    logic [23:0] block;
    logic [24:0] count;
    logic        full;
  } entry_t;

  typedef struct packed {
    logic        start_le;
    logic        end_eq;
    logic        end_gt;
    logic [24:0] rem_cnt;
    logic [24:0] inc_cnt;
  } alu_res_t;

endpackage

// File: rtl/core/crct_if.sv
interface crct_req_if import crct_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crct_rsp_if import crct_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/crct_ram.sv
module crct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/crct_alu.sv
module crct_alu import crct_pkg::*; (
  input  entry_t      ent,
  input  logic [23:0] blk,
  output alu_res_t    res
);

  logic [25:0]        end_w;
  logic signed [26:0] diff;

  assign end_w = 26'(ent.block) + 26'(ent.count);
  assign diff = signed'(27'(end_w)) - signed'(27'(blk));

  always_comb begin
    res.start_le = (ent.block <= blk);
    res.end_eq = (diff == 27'sd0);
    res.end_gt = (diff > 27'sd0);
    res.rem_cnt = (diff > 27'sd16777216) ? ALL_BLOCKS : diff[24:0];
    res.inc_cnt = ent.count + 25'd1;
  end

endmodule

// File: rtl/core/crct_ctrl.sv
module crct_ctrl import crct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  output logic        ram_we,
  output idx_t        ram_waddr,
  output entry_t      ram_wdata,
  output logic        ram_re,
  output idx_t        ram_raddr,
  input  entry_t      ram_rdata,
  output logic [23:0] alu_blk,
  input  alu_res_t    alu_res
);

  function automatic rsp_t make_rsp(status_t st, logic [7:0] s, logic vld, entry_t ent,
                                    fill_t fl);
    rsp_t r;
    r.status = st;
    r.slot_used = s;
    r.entry_valid = vld;
    r.entry_image = vld ? ent.image : 16'd0;
    r.entry_block = vld ? ent.block : 24'd0;
    r.entry_count = vld ? ent.count : 25'd0;
    r.entry_full = vld ? ent.full : 1'b0;
    r.fill_count = 9'(fl);
    return r;
  endfunction

  state_t                 state_r, state_nxt;
  req_t                   req_r, req_nxt;
  fill_t                  scan_r, scan_nxt;
  logic                   pend_r, pend_nxt;
  idx_t                   pidx_r, pidx_nxt;
  logic                   have_free_r, have_free_nxt;
  idx_t                   free_r, free_nxt;
  fill_t                  fill_r, fill_nxt;
  logic [TABLE_DEPTH-1:0] used_r;
  rsp_t                   res_r, res_nxt;
  logic                   out_vld_r, out_vld_nxt;
  rsp_t                   out_r, out_nxt;
  logic                   used_we;
  idx_t                   used_idx;
  logic                   used_val;
  logic                   scan_hit;
  logic                   slot_ok;
  idx_t                   slot_idx;
  logic                   slot_live;
  entry_t                 new_ent;
  idx_t                   alloc_idx;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data = out_r;
  assign alu_blk = req_r.block;

  assign slot_ok = (32'(req_r.slot) < TABLE_DEPTH);
  assign slot_idx = idx_t'(32'(req_r.slot));
  assign slot_live = slot_ok && used_r[slot_idx];

  always_comb begin
    new_ent.image = req_r.image_id;
    new_ent.block = req_r.whole_image ? 24'd0 : req_r.block;
    new_ent.count = req_r.whole_image ? ALL_BLOCKS : 25'd1;
    new_ent.full = req_r.whole_image;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    scan_nxt = scan_r;
    pend_nxt = 1'b0;
    pidx_nxt = pidx_r;
    have_free_nxt = have_free_r;
    free_nxt = free_r;
    fill_nxt = fill_r;
    res_nxt = res_r;
    out_vld_nxt = out_vld_r;
    out_nxt = out_r;
    used_we = 1'b0;
    used_idx = '0;
    used_val = 1'b0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_ent;
    ram_re = 1'b0;
    ram_raddr = '0;
    scan_hit = 1'b0;
    alloc_idx = '0;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.cmd == CMD_REQUEST) begin
            scan_nxt = '0;
            have_free_nxt = 1'b0;
            free_nxt = '0;
            state_nxt = S_SCAN;
          end else begin
            ram_re = 1'b1;
            ram_raddr = idx_t'(32'(in_data.slot));
            state_nxt = S_FETCH;
          end
        end
      end

      S_SCAN: begin
        if (pend_r) begin
          if (!used_r[pidx_r]) begin
            if (!have_free_r) begin
              have_free_nxt = 1'b1;
              free_nxt = pidx_r;
            end
          end else if (ram_rdata.image == req_r.image_id) begin
            if (req_r.whole_image) begin
              scan_hit = 1'b1;
              ram_we = 1'b1;
              ram_waddr = pidx_r;
              ram_wdata = new_ent;
              res_nxt = make_rsp(ST_RESET_FULL, 8'(pidx_r), 1'b1, new_ent, fill_r);
            end else if (alu_res.start_le) begin
              if (ram_rdata.full) begin
                scan_hit = 1'b1;
                res_nxt = make_rsp(ST_COVERED_FULL, 8'(pidx_r), 1'b1, ram_rdata, fill_r);
              end else if (alu_res.end_eq) begin
                scan_hit = 1'b1;
                ram_we = 1'b1;
                ram_waddr = pidx_r;
                ram_wdata = ram_rdata;
                ram_wdata.count = alu_res.inc_cnt;
                res_nxt = make_rsp(ST_EXTENDED, 8'(pidx_r), 1'b1, ram_wdata, fill_r);
              end else if (alu_res.end_gt) begin
                scan_hit = 1'b1;
                res_nxt = make_rsp(ST_COVERED, 8'(pidx_r), 1'b1, ram_rdata, fill_r);
              end
            end
          end
        end

        if (scan_hit) begin
          state_nxt = S_EMIT;
        end else if (scan_r < fill_r) begin
          ram_re = 1'b1;
          ram_raddr = scan_r[IDX_W-1:0];
          pidx_nxt = scan_r[IDX_W-1:0];
          pend_nxt = 1'b1;
          scan_nxt = scan_r + fill_t'(1);
        end else if (!pend_r) begin
          state_nxt = S_EMIT;
          if (!have_free_r && (32'(fill_r) >= TABLE_DEPTH)) begin
            res_nxt = make_rsp(ST_DISCARD, 8'd0, 1'b0, new_ent, fill_r);
          end else begin
            if (have_free_r) begin
              alloc_idx = free_r;
            end else begin
              alloc_idx = fill_r[IDX_W-1:0];
              fill_nxt = fill_r + fill_t'(1);
            end
            used_we = 1'b1;
            used_idx = alloc_idx;
            used_val = 1'b1;
            ram_we = 1'b1;
            ram_waddr = alloc_idx;
            ram_wdata = new_ent;
            res_nxt = make_rsp(ST_NEW, 8'(alloc_idx), 1'b1, new_ent, fill_nxt);
          end
        end
      end

      S_FETCH: begin
        state_nxt = S_EMIT;
        case (req_r.cmd)
          CMD_ADVANCE: begin
            if (slot_live && ram_rdata.full) begin
              ram_we = 1'b1;
              ram_waddr = slot_idx;
              ram_wdata = ram_rdata;
              ram_wdata.block = req_r.block;
              res_nxt = make_rsp(ST_ADVANCED, req_r.slot, 1'b1, ram_wdata, fill_r);
            end else if (slot_live && !alu_res.end_gt) begin
              used_we = 1'b1;
              used_idx = slot_idx;
              used_val = 1'b0;
              if ((fill_t'(slot_idx) + fill_t'(1)) == fill_r) begin
                fill_nxt = fill_r - fill_t'(1);
              end
              res_nxt = make_rsp(ST_ADVANCED, req_r.slot, 1'b0, ram_rdata, fill_nxt);
            end else if (slot_live) begin
              ram_we = 1'b1;
              ram_waddr = slot_idx;
              ram_wdata = ram_rdata;
              ram_wdata.block = req_r.block;
              ram_wdata.count = alu_res.rem_cnt;
              res_nxt = make_rsp(ST_ADVANCED, req_r.slot, 1'b1, ram_wdata, fill_r);
            end else begin
              res_nxt = make_rsp(ST_ADVANCED, req_r.slot, 1'b0, ram_rdata, fill_r);
            end
          end
          CMD_RELEASE: begin
            if (slot_ok) begin
              used_we = 1'b1;
              used_idx = slot_idx;
              used_val = 1'b0;
              if ((fill_t'(slot_idx) + fill_t'(1)) == fill_r) begin
                fill_nxt = fill_r - fill_t'(1);
              end
            end
            res_nxt = make_rsp(ST_FREED, req_r.slot, 1'b0, ram_rdata, fill_nxt);
          end
          CMD_READ: begin
            res_nxt = make_rsp(ST_READ, req_r.slot, slot_live, ram_rdata, fill_r);
          end
          default: begin
            res_nxt = make_rsp(ST_READ, req_r.slot, slot_live, ram_rdata, fill_r);
          end
        endcase
      end

      S_EMIT: begin
        if (!out_vld_r || out_ready) begin
          out_nxt = res_r;
          out_vld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= 1'b0;
      have_free_r <= 1'b0;
      fill_r <= '0;
      used_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
      have_free_r <= have_free_nxt;
      fill_r <= fill_nxt;
      out_vld_r <= out_vld_nxt;
      if (used_we) begin
        used_r[used_idx] <= used_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    scan_r <= scan_nxt;
    pidx_r <= pidx_nxt;
    free_r <= free_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

// File: rtl/core/check_request_coalescing_table_top.sv
// Channel   Direction  Payload
// in_req    sink       cmd, image_id, block, whole_image, slot
// out_rsp   source     status, slot_used, entry_*, fill_count
//
// A request scans the filled part of the table and then loads the output register;
// the shared adder and compare look at one stored entry per cycle until a merge hits.
// Advance, release and read go through one table read, one update and one output load.
// Reset clears the used flags and the fill length directly; there is no clearing pass.
// A finished result waits in the output register while the next request is accepted.
// A newer result holds in the emit step until out_rsp.ready takes the older one.
module check_request_coalescing_table_top import crct_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  crct_req_if.sink  in_req,
  crct_rsp_if.source out_rsp
);

  logic        ram_we;
  idx_t        ram_waddr;
  entry_t      ram_wdata;
  logic        ram_re;
  idx_t        ram_raddr;
  entry_t      ram_rdata;
  logic [23:0] alu_blk;
  alu_res_t    alu_res;

  crct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_data   (in_req.data),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_data  (out_rsp.data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .alu_blk   (alu_blk),
    .alu_res   (alu_res)
  );

  crct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crct_alu u_alu (
    .ent (ram_rdata),
    .blk (alu_blk),
    .res (alu_res)
  );

endmodule

// File: rtl/core/crct_checker.sv
module crct_checker import crct_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while the previous one was still in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.fill_count) <= TABLE_DEPTH)
    else $error("Fill length exceeds the table depth.");

  a_dead_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_valid |->
      out_data.entry_image == 16'd0 && out_data.entry_block == 24'd0 &&
      out_data.entry_count == 25'd0 && !out_data.entry_full)
    else $error("Entry fields not cleared for a slot without a live request.");

  a_discard_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DISCARD |->
      32'(out_data.fill_count) == TABLE_DEPTH && !out_data.entry_valid)
    else $error("Request discarded while the table was not full.");

endmodule

bind check_request_coalescing_table_top crct_checker u_crct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);
